### rtl/sha512_pkg.sv
`timescale 1ns / 1ps
package sha512_pkg;

  localparam int WordBits  = 64;
  localparam int BlockWords = 16;
  localparam int Rounds     = 80;
  localparam int LenWordIdx = 14;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [6:0] round_t;
  typedef logic [3:0] widx_t;

  typedef enum logic [3:0] {
    ST_FILL,
    ST_PAD1,
    ST_PADZ,
    ST_LEN,
    ST_INIT,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic   clear_buf;
    logic   put_byte;
    logic   put_pad;
    logic   put_zero;
    logic   put_len;
    logic   load_vars;
    logic   do_round;
    logic   add_chain;
    logic   restart;
    logic   shift_out;
  } cmd_t;

  typedef struct packed {
    logic   byte_last;
    logic   pad_fits;
    logic   zero_done;
    logic   round_last;
  } stat_t;

  localparam word_t InitHash [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  localparam word_t RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
    64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
    64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
    64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
    64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
    64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
    64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
    64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
    64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
    64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
    64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
    64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
    64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
    64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
    64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
    64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
    64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
    64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
    64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
    64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
    64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

  function automatic word_t ror(input word_t v, input int s);
    ror = (v >> s) | (v << (WordBits - s));
  endfunction

endpackage

### rtl/sha512_if.sv
`timescale 1ns / 1ps
interface sha512_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source(output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink(input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha512_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        final_word;
  modport source(output valid, digest_word, final_word, input ready);
  modport sink(input valid, digest_word, final_word, output ready);
endinterface

### rtl/sha512_ctrl.sv
`timescale 1ns / 1ps
module sha512_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             byte_present,
  input  logic             end_of_message,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             out_last,
  input  sha512_pkg::stat_t stat,
  output sha512_pkg::cmd_t  cmd
);
  import sha512_pkg::*;

  state_t state, state_next;
  logic   final_blk, final_blk_next;
  logic   pend_end, pend_end_next;
  logic [2:0] out_cnt, out_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      final_blk <= 1'b0;
      pend_end  <= 1'b0;
      out_cnt   <= '0;
    end else begin
      state     <= state_next;
      final_blk <= final_blk_next;
      pend_end  <= pend_end_next;
      out_cnt   <= out_cnt_next;
    end
  end

  always_comb begin
    state_next     = state;
    final_blk_next = final_blk;
    pend_end_next  = pend_end;
    out_cnt_next   = out_cnt;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    out_last       = (out_cnt == 3'd7);
    case (state)
      ST_FILL: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.put_byte = byte_present;
          if (byte_present && stat.byte_last) begin
            final_blk_next = 1'b0;
            pend_end_next  = end_of_message;
            state_next     = ST_INIT;
          end else if (end_of_message) begin
            state_next = ST_PAD1;
          end
        end
      end
      ST_PAD1: begin
        cmd.put_pad = 1'b1;
        state_next  = ST_PADZ;
      end
      ST_PADZ: begin
        if (stat.zero_done) begin
          if (stat.pad_fits) begin
            state_next = ST_LEN;
          end else begin
            final_blk_next = 1'b0;
            pend_end_next  = 1'b0;
            state_next     = ST_INIT;
          end
        end else begin
          cmd.put_zero = 1'b1;
        end
      end
      ST_LEN: begin
        cmd.put_len    = 1'b1;
        final_blk_next = 1'b1;
        state_next     = ST_INIT;
      end
      ST_INIT: begin
        cmd.load_vars = 1'b1;
        state_next    = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.do_round = 1'b1;
        if (stat.round_last) state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add_chain = 1'b1;
        cmd.clear_buf = 1'b1;
        if (final_blk) begin
          out_cnt_next = '0;
          state_next   = ST_OUT;
        end else if (pend_end) begin
          pend_end_next = 1'b0;
          state_next    = ST_PAD1;
        end else begin
          // after an overflow pad block, the second block gets zeros up to the length
          state_next = stat.pad_fits ? ST_FILL : ST_PADZ;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.shift_out = 1'b1;
          out_cnt_next  = out_cnt + 3'd1;
          if (out_cnt == 3'd7) begin
            cmd.restart    = 1'b1;
            final_blk_next = 1'b0;
            state_next     = ST_FILL;
          end
        end
      end
      default: state_next = ST_FILL;
    endcase
  end

endmodule

### rtl/sha512_dp.sv
`timescale 1ns / 1ps
module sha512_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       data_byte,
  input  sha512_pkg::cmd_t  cmd,
  output sha512_pkg::stat_t stat,
  output logic [63:0]      digest_word
);
  import sha512_pkg::*;

  word_t  chain [8];
  word_t  vars [8];
  word_t  sched [16];
  logic [7:0] fill;
  logic [63:0] bytes_seen;
  logic   ovf_blk;
  round_t rnd;

  word_t  wcur, w15, w2, w7, w16, s0, s1, wnew, t1, t2;
  widx_t  wi;
  logic [3:0] bi;
  logic [2:0] bo;

  assign bi = fill[6:3];
  assign bo = fill[2:0];
  assign wi = rnd[3:0];

  assign stat.byte_last  = (fill == 8'd127);
  assign stat.pad_fits   = !ovf_blk;
  assign stat.zero_done  = ovf_blk ? (fill == 8'd128) : (fill == 8'd112);
  assign stat.round_last = (rnd == round_t'(Rounds - 1));

  assign w15 = sched[widx_t'(wi + 4'd1)];
  assign w2  = sched[widx_t'(wi + 4'd14)];
  assign w7  = sched[widx_t'(wi + 4'd9)];
  assign w16 = sched[wi];
  assign s0  = ror(w15, 1) ^ ror(w15, 8) ^ (w15 >> 7);
  assign s1  = ror(w2, 19) ^ ror(w2, 61) ^ (w2 >> 6);
  assign wnew = w16 + s0 + s1 + w7;
  assign wcur = (rnd < round_t'(BlockWords)) ? w16 : wnew;
  assign t1 = vars[7] + (ror(vars[4], 14) ^ ror(vars[4], 18) ^ ror(vars[4], 41))
            + ((vars[4] & vars[5]) ^ (~vars[4] & vars[6])) + RoundK[rnd] + wcur;
  assign t2 = (ror(vars[0], 28) ^ ror(vars[0], 34) ^ ror(vars[0], 39))
            + ((vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]));

  assign digest_word = chain[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      bytes_seen <= '0;
      ovf_blk    <= 1'b0;
      rnd        <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= InitHash[i];
    end else begin
      if (cmd.put_byte) begin
        sched[bi][8*(7-bo) +: 8] <= data_byte;
        fill       <= (fill == 8'd127) ? 8'd0 : fill + 8'd1;
        bytes_seen <= bytes_seen + 64'd1;
      end
      if (cmd.put_pad) begin
        sched[bi][8*(7-bo) +: 8] <= 8'h80;
        ovf_blk <= (fill >= 8'd112);
        fill    <= fill + 8'd1;
      end
      if (cmd.put_zero) begin
        sched[bi][8*(7-bo) +: 8] <= 8'h00;
        fill <= fill + 8'd1;
      end
      if (cmd.put_len) begin
        sched[widx_t'(LenWordIdx)]     <= {61'd0, bytes_seen[63:61]};
        sched[widx_t'(LenWordIdx + 1)] <= {bytes_seen[60:0], 3'b000};
      end
      if (cmd.load_vars) begin
        for (int i = 0; i < 8; i++) vars[i] <= chain[i];
        rnd <= '0;
      end
      if (cmd.do_round) begin
        sched[wi] <= wcur;
        vars[7] <= vars[6];
        vars[6] <= vars[5];
        vars[5] <= vars[4];
        vars[4] <= vars[3] + t1;
        vars[3] <= vars[2];
        vars[2] <= vars[1];
        vars[1] <= vars[0];
        vars[0] <= t1 + t2;
        rnd <= rnd + round_t'(1);
      end
      if (cmd.add_chain) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + vars[i];
        if (ovf_blk) begin
          ovf_blk <= 1'b0;
          fill    <= '0;
        end
      end
      if (cmd.shift_out && !cmd.restart) begin
        for (int i = 0; i < 7; i++) chain[i] <= chain[i+1];
        chain[7] <= chain[0];
      end
      if (cmd.restart) begin
        for (int i = 0; i < 8; i++) chain[i] <= InitHash[i];
        fill       <= '0;
        bytes_seen <= '0;
        ovf_blk    <= 1'b0;
      end
      if (cmd.clear_buf) rnd <= '0;
    end
  end

endmodule

### rtl/sha512_stream_hash_unit.sv
`timescale 1ns / 1ps
// channel   dir  payload                                   last
// in_ch     in   data_byte[7:0] byte_present end_of_message  -
// out_ch    out  digest_word[63:0] final_word               final_word
// A byte is taken per cycle while a block fills with in_ch.valid high;
// a full block then runs load, 80 rounds of one shared round unit and
// chain add. End of message: padding, then one or two compressions,
// then eight digest words, each held until taken.
// Reset (rst, synchronous) restores the initial hash value and clears counts.
module sha512_stream_hash_unit (
  input logic clk,
  input logic rst,
  sha512_in_if.sink    in_ch,
  sha512_out_if.source out_ch
);
  import sha512_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sha512_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .byte_present  (in_ch.byte_present),
    .end_of_message(in_ch.end_of_message),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_last      (out_ch.final_word),
    .stat          (stat),
    .cmd           (cmd)
  );

  sha512_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (in_ch.data_byte),
    .cmd        (cmd),
    .stat       (stat),
    .digest_word(out_ch.digest_word)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid)) else $error("input taken while output pending");
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.put_byte, cmd.put_pad, cmd.put_zero, cmd.put_len, cmd.do_round}))
    else $error("conflicting buffer writes");
  a_final_restart: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.final_word) |=> in_ch.ready)
    else $error("no restart after last word");

endmodule
